// ----- rtl/lfu_pkg.sv -----
`timescale 1ns / 1ps
package lfu_pkg;

  localparam int CFG_W        = 5;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 16;
  localparam int STAMP_W      = 32;
  localparam int CAPACITY_DEF = 16;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   use_count;
    logic [STAMP_W-1:0] stamp;
  } lfu_entry_t;

  localparam int ENTRY_W = $bits(lfu_entry_t);

  // controller to datapath
  typedef struct packed {
    logic start;   // latch the transaction, clear the scan trackers
    logic issue;   // read the entry at the scan index, advance it
    logic commit;  // write back the table and load the result register
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;
  } lfu_sts_t;

endpackage

// ----- rtl/lfu_ram.sv -----
`timescale 1ns / 1ps
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/lfu_ctrl.sv -----
`timescale 1ns / 1ps
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lfu_pkg::lfu_sts_t sts,
  output lfu_pkg::lfu_cmd_t cmd
);
  import lfu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  // result register can take a new result when empty or being taken now
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.start  = (state_r == ST_IDLE) && in_valid;
    cmd.issue  = (state_r == ST_SCAN);
    cmd.commit = (state_r == ST_COMMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // load on commit, hold while stalled, drop once taken
      out_valid_r <= cmd.commit || (out_valid_r && out_stall);
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts.last_issue) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/lfu_datapath.sv -----
`timescale 1ns / 1ps
module lfu_datapath #(
  parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lfu_pkg::lfu_cmd_t                 cmd,
  output lfu_pkg::lfu_sts_t                 sts,
  input  logic                              cfg_wr_en,
  input  logic        [lfu_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                              in_opcode,
  input  logic signed [lfu_pkg::KEY_W-1:0]  in_lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  in_store_value,
  output logic                              out_found,
  output logic signed [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                              out_evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  out_evicted_key
);
  import lfu_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  // configuration and persistent state
  logic [CFG_W-1:0]    cap_cfg_r;
  logic [CAPACITY-1:0] valid_r;
  logic [OCC_W-1:0]    occ_r;
  logic [STAMP_W-1:0]  clock_r;

  // latched transaction
  logic                op_r;
  logic [KEY_W-1:0]    key_r;
  logic [VAL_W-1:0]    val_r;

  // scan pipeline
  logic [IDX_W-1:0]    scan_idx_r;
  logic                cmp_vld_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  lfu_entry_t          rd_entry;

  // scan trackers
  logic                has_hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [VAL_W-1:0]    hit_val_r;
  logic [CNT_W-1:0]    hit_cnt_r;
  logic                has_free_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic                has_vic_r;
  logic [IDX_W-1:0]    vic_idx_r;
  logic [KEY_W-1:0]    vic_key_r;
  logic [CNT_W-1:0]    vic_cnt_r;
  logic [STAMP_W-1:0]  vic_stamp_r;

  // result register
  logic                found_r;
  logic [VAL_W-1:0]    read_val_r;
  logic                evicted_r;
  logic [KEY_W-1:0]    evicted_key_r;

  // commit decisions
  logic [CMP_W-1:0]    cap_eff;
  logic [STAMP_W-1:0]  clock_inc;
  logic                wr_en;
  logic                ram_wr_en;
  logic [IDX_W-1:0]    wr_addr;
  lfu_entry_t          wr_entry;
  logic                set_valid;
  logic                occ_inc;
  logic                res_found;
  logic [VAL_W-1:0]    res_val;
  logic                res_evicted;
  logic [KEY_W-1:0]    res_ekey;
  logic                cmp_entry_vld;
  logic                vic_better;

  // write the table only on the commit cycle
  assign ram_wr_en = cmd.commit && wr_en;

  lfu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (scan_idx_r),
    .rd_data (rd_entry)
  );

  assign sts.last_issue = (scan_idx_r == IDX_W'(CAPACITY - 1));

  assign cmp_entry_vld = valid_r[cmp_idx_r];
  assign vic_better    = !has_vic_r ||
                         ({rd_entry.use_count, rd_entry.stamp} <
                          {vic_cnt_r, vic_stamp_r});

  assign cap_eff   = (CMP_W'(cap_cfg_r) < CMP_W'(CAPACITY)) ? CMP_W'(cap_cfg_r)
                                                            : CMP_W'(CAPACITY);
  assign clock_inc = (clock_r != '1) ? clock_r + STAMP_W'(1) : clock_r;

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = hit_idx_r;
    wr_entry    = '0;
    set_valid   = 1'b0;
    occ_inc     = 1'b0;
    res_found   = 1'b0;
    res_val     = '0;
    res_evicted = 1'b0;
    res_ekey    = '0;
    wr_entry.key       = key_r;
    wr_entry.value     = val_r;
    wr_entry.use_count = CNT_W'(1);
    wr_entry.stamp     = clock_inc;
    if (cap_eff != '0) begin
      if (has_hit_r) begin
        res_found          = 1'b1;
        wr_en              = 1'b1;
        wr_addr            = hit_idx_r;
        wr_entry.use_count = (hit_cnt_r != '1) ? hit_cnt_r + CNT_W'(1) : hit_cnt_r;
        if (op_r == OP_GET) begin
          res_val        = hit_val_r;
          wr_entry.value = hit_val_r;
        end
      end else if (op_r == OP_PUT) begin
        if ((CMP_W'(occ_r) >= cap_eff) && has_vic_r) begin
          wr_en       = 1'b1;
          wr_addr     = vic_idx_r;
          res_evicted = 1'b1;
          res_ekey    = vic_key_r;
        end else if (has_free_r) begin
          wr_en     = 1'b1;
          wr_addr   = free_idx_r;
          set_valid = 1'b1;
          occ_inc   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r  <= CAP_RESET;
      valid_r    <= '0;
      occ_r      <= '0;
      clock_r    <= '0;
      cmp_vld_r  <= 1'b0;
      scan_idx_r <= '0;
      has_hit_r  <= 1'b0;
      has_free_r <= 1'b0;
      has_vic_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_cfg_r <= cfg_wr_data;
      end

      cmp_vld_r <= cmd.issue;
      cmp_idx_r <= scan_idx_r;

      if (cmd.start) begin
        op_r       <= in_opcode;
        key_r      <= in_lookup_key;
        val_r      <= in_store_value;
        scan_idx_r <= '0;
        has_hit_r  <= 1'b0;
        has_free_r <= 1'b0;
        has_vic_r  <= 1'b0;
      end else if (cmd.issue) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end

      if (cmp_vld_r) begin
        if (!cmp_entry_vld) begin
          if (!has_free_r) begin
            has_free_r <= 1'b1;
            free_idx_r <= cmp_idx_r;
          end
        end else begin
          if (!has_hit_r && (rd_entry.key == key_r)) begin
            has_hit_r <= 1'b1;
            hit_idx_r <= cmp_idx_r;
            hit_val_r <= rd_entry.value;
            hit_cnt_r <= rd_entry.use_count;
          end
          if (vic_better) begin
            has_vic_r   <= 1'b1;
            vic_idx_r   <= cmp_idx_r;
            vic_key_r   <= rd_entry.key;
            vic_cnt_r   <= rd_entry.use_count;
            vic_stamp_r <= rd_entry.stamp;
          end
        end
      end

      if (cmd.commit) begin
        if (wr_en) begin
          clock_r <= clock_inc;
        end
        if (set_valid) begin
          valid_r[wr_addr] <= 1'b1;
        end
        if (occ_inc) begin
          occ_r <= occ_r + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r       <= res_found;
      read_val_r    <= res_val;
      evicted_r     <= res_evicted;
      evicted_key_r <= res_ekey;
    end
  end

  assign out_found       = found_r;
  assign out_read_value  = read_val_r;
  assign out_evicted     = evicted_r;
  assign out_evicted_key = evicted_key_r;

endmodule

// ----- rtl/lfu_cache_table.sv -----
// Transactions run one at a time: in_stall is high from the accepting edge
//   until the commit, which waits while an earlier result is stalled; the pace
//   is set by the scan that reads the read port of the entry RAM once per slot.
// Reset (rst_n low, synchronous): all entries invalid, occupancy and access
//   clock zero, capacity register 16; no clearing pass, ready right after reset.
`timescale 1ns / 1ps
module lfu_cache_table #(
  parameter int CAPACITY = lfu_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic        [lfu_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic signed [lfu_pkg::KEY_W-1:0]  in_lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  in_store_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic signed [lfu_pkg::VAL_W-1:0]  out_read_value,
  output logic                              out_evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  out_evicted_key
);
  import lfu_pkg::*;

  // The controller sequences each transaction: accept, scan every slot
  // through the entry RAM (one read per cycle, compare in the cycle after each read),
  // then commit at most one write-back and load the result register. The commit
  // holds while an earlier result still waits on out_stall, so a new
  // transaction can be accepted and scanned behind a stalled result.
  lfu_cmd_t cmd;
  lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the valid bits, occupancy, access clock and the
  // capacity register; it tracks the first key match, the lowest free slot
  // and the (count, stamp) minimum during the scan, lowest slot on ties.
  lfu_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_opcode       (in_opcode),
    .in_lookup_key   (in_lookup_key),
    .in_store_value  (in_store_value),
    .out_found       (out_found),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule
